@@ sv/rawdc_pkg.sv @@
// Shared constants, state encoding and control types for the working-day counter.
`default_nettype none

package rawdc_pkg;

    localparam int POS_W             = 13;
    localparam int S_TDATA_W         = 32;
    localparam int M_TDATA_W         = 16;
    localparam int DAYS_DEFAULT      = 4096;
    localparam int WORD_BITS_DEFAULT = 64;

    localparam logic CMD_IDLE = 1'b0;
    localparam logic CMD_WORK = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOC1,
        ST_LOC2,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clear;
        logic cmd;
    } count_ctl_t;

endpackage

`default_nettype wire

@@ sv/rawdc_locate.sv @@
// Splits the first and last day positions into bitmap word index and bit offset.
`default_nettype none

module rawdc_locate
    import rawdc_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEFAULT,
    parameter int WIDX_W    = 6,
    parameter int BIT_W     = 6
)
(
    input  wire logic              clk,
    input  wire logic [POS_W-1:0]  first_pos,
    input  wire logic [POS_W-1:0]  last_pos,
    output logic      [WIDX_W-1:0] first_word,
    output logic      [BIT_W-1:0]  first_bit,
    output logic      [WIDX_W-1:0] last_word,
    output logic      [BIT_W-1:0]  last_bit
);

    // The quotient comes from a multiplication by a rounded-up reciprocal,
    // which is exact for every position of POS_W bits.
    localparam int SHIFT  = POS_W + $clog2(WORD_BITS);
    localparam int RECIP  = ((2 ** SHIFT) + WORD_BITS - 1) / WORD_BITS;
    localparam int PROD_W = POS_W + SHIFT + 1;

    logic [PROD_W-1:0] first_prod;
    logic [PROD_W-1:0] last_prod;
    logic [WIDX_W-1:0] first_word_reg;
    logic [WIDX_W-1:0] last_word_reg;
    logic [POS_W-1:0]  first_pos_reg;
    logic [POS_W-1:0]  last_pos_reg;
    logic [BIT_W-1:0]  first_bit_reg;
    logic [BIT_W-1:0]  last_bit_reg;

    assign first_prod = PROD_W'(first_pos) * PROD_W'(RECIP);
    assign last_prod  = PROD_W'(last_pos) * PROD_W'(RECIP);

    always_ff @(posedge clk)
    begin
        first_word_reg <= first_prod[SHIFT +: WIDX_W];
        last_word_reg  <= last_prod[SHIFT +: WIDX_W];
        first_pos_reg  <= first_pos;
        last_pos_reg   <= last_pos;
        first_bit_reg  <= BIT_W'(first_pos_reg - POS_W'(first_word_reg * WORD_BITS));
        last_bit_reg   <= BIT_W'(last_pos_reg - POS_W'(last_word_reg * WORD_BITS));
    end

    assign first_word = first_word_reg;
    assign first_bit  = first_bit_reg;
    assign last_word  = last_word_reg;
    assign last_bit   = last_bit_reg;

endmodule

`default_nettype wire

@@ sv/rawdc_word_unit.sv @@
// Shared word unit: applies the range mask of one bitmap word for the current command.
`default_nettype none

module rawdc_word_unit
    import rawdc_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEFAULT,
    parameter int WIDX_W    = 6,
    parameter int BIT_W     = 6
)
(
    input  wire logic [WORD_BITS-1:0] old_word,
    input  wire logic [WIDX_W-1:0]    word_idx,
    input  wire logic [WIDX_W-1:0]    first_word,
    input  wire logic [BIT_W-1:0]     first_bit,
    input  wire logic [WIDX_W-1:0]    last_word,
    input  wire logic [BIT_W-1:0]     last_bit,
    input  wire logic                 cmd,
    output logic      [WORD_BITS-1:0] new_word,
    output logic      [WORD_BITS-1:0] changed
);

    logic [BIT_W-1:0]     lo;
    logic [BIT_W-1:0]     hi;
    logic [WORD_BITS-1:0] mask;

    always_comb
    begin
        lo = (word_idx == first_word) ? first_bit : '0;
        hi = (word_idx == last_word) ? last_bit : BIT_W'(WORD_BITS - 1);
        for (int i = 0; i < WORD_BITS; i++)
        begin
            mask[i] = (BIT_W'(i) >= lo) && (BIT_W'(i) <= hi);
        end
        if (cmd == CMD_IDLE)
        begin
            new_word = old_word | mask;
        end
        else
        begin
            new_word = old_word & ~mask;
        end
        changed = old_word ^ new_word;
    end

endmodule

`default_nettype wire

@@ sv/rawdc_count.sv @@
// Pipelined population count of changed bits and the running non-working day count.
`default_nettype none

module rawdc_count
    import rawdc_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEFAULT,
    parameter int DAY_W     = 13
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire count_ctl_t           ctl,
    input  wire logic                 in_valid,
    input  wire logic [WORD_BITS-1:0] in_bits,
    output logic                      busy,
    output logic      [DAY_W-1:0]     idle_count
);

    localparam int POP_W = $clog2(WORD_BITS + 1);

    logic [WORD_BITS-1:0] chg_reg;
    logic                 chg_v_reg;
    logic [POP_W-1:0]     pop_reg;
    logic                 pop_v_reg;
    logic [DAY_W-1:0]     idle_count_reg;
    logic [DAY_W-1:0]     idle_count_next;

    always_comb
    begin
        idle_count_next = idle_count_reg;
        if (ctl.clear)
        begin
            idle_count_next = '0;
        end
        else if (pop_v_reg)
        begin
            if (ctl.cmd == CMD_WORK)
            begin
                idle_count_next = idle_count_reg - DAY_W'(pop_reg);
            end
            else
            begin
                idle_count_next = idle_count_reg + DAY_W'(pop_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chg_v_reg      <= 1'b0;
            pop_v_reg      <= 1'b0;
            idle_count_reg <= '0;
        end
        else
        begin
            chg_v_reg      <= in_valid && !ctl.clear;
            pop_v_reg      <= chg_v_reg && !ctl.clear;
            idle_count_reg <= idle_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chg_reg <= in_bits;
        pop_reg <= POP_W'($countones(chg_reg));
    end

    assign busy       = chg_v_reg || pop_v_reg;
    assign idle_count = idle_count_reg;

endmodule

`default_nettype wire

@@ sv/range_assign_working_day_counter.sv @@
// Top level of the working-day counter: sequencer, bitmap memory and stream ports.
//
//  Channel  Direction  Handshake            Payload
//  s_*      in         s_tvalid / s_tready  tdata: first_day, last_day; tuser: command
//  m_*      out        m_tvalid / m_tready  tdata: working_days; tuser: rejected
//  cfg_*    in         cfg_valid / cfg_ready cfg_data: days_in_use
//
// A valid range is walked by the single word unit, which reads, modifies and writes one
// memory word per cycle; the next transaction is taken only after the result is loaded.
// A rejected range skips the walk and goes straight to the result.
// After reset and after every configuration write, a clearing pass of one word per
// cycle (DAYS / WORD_BITS words, rounded up, at most 8191 days) runs while s_tready is low.
// A stalled result waits in the output register; a new transaction is still taken.
`default_nettype none

module range_assign_working_day_counter
    import rawdc_pkg::*;
#(
    parameter int DAYS      = DAYS_DEFAULT,
    parameter int WORD_BITS = WORD_BITS_DEFAULT
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // first_day[12:0], last_day[25:13], zeros
    input  wire logic [0:0]           s_tuser,  // command[0]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,  // working_days[12:0], zeros
    output logic      [0:0]           m_tuser,  // rejected[0]
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [POS_W-1:0]     cfg_data
);

    localparam int DAY_LIMIT = (DAYS < (2 ** POS_W) - 1) ? DAYS : (2 ** POS_W) - 1;
    localparam int MEM_WORDS = (DAY_LIMIT + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int DAY_W     = ($clog2(DAYS + 1) > POS_W) ? $clog2(DAYS + 1) : POS_W;

    state_t               state_reg;
    state_t               state_next;
    logic [WIDX_W-1:0]    clr_reg;
    logic [WIDX_W-1:0]    clr_next;
    logic [DAY_W-1:0]     days_reg;
    logic [DAY_W-1:0]     days_next;
    logic [WIDX_W-1:0]    rd_word_reg;
    logic [WIDX_W-1:0]    rd_word_next;
    logic                 wr_v_reg;
    logic                 wr_v_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 out_load;

    logic                 cmd_reg;
    logic [POS_W-1:0]     first_reg;
    logic [POS_W-1:0]     last_reg;
    logic                 bad_reg;
    logic [WIDX_W-1:0]    wr_word_reg;
    logic [WORD_BITS-1:0] mem_rdata_reg;
    logic [POS_W-1:0]     out_days_reg;
    logic                 out_rej_reg;

    logic                 s_accept;
    logic                 cfg_accept;
    logic [POS_W-1:0]     in_first;
    logic [POS_W-1:0]     in_last;
    logic                 in_bad;
    logic [DAY_W-1:0]     cfg_sat;

    logic [WIDX_W-1:0]    loc_fw;
    logic [BIT_W-1:0]     loc_fb;
    logic [WIDX_W-1:0]    loc_lw;
    logic [BIT_W-1:0]     loc_lb;
    logic [WORD_BITS-1:0] new_word;
    logic [WORD_BITS-1:0] changed;

    logic                 mem_we;
    logic [WIDX_W-1:0]    mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [WORD_BITS-1:0] mem [MEM_WORDS];

    count_ctl_t           cnt_ctl;
    logic                 cnt_busy;
    logic [DAY_W-1:0]     idle_count;

    assign in_first   = s_tdata[POS_W-1:0];
    assign in_last    = s_tdata[2*POS_W-1:POS_W];
    assign s_accept   = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign in_bad     = (in_first == '0) || (in_first > in_last)
                        || (DAY_W'(in_last) > days_reg);
    assign cfg_sat    = (DAY_W'(cfg_data) > DAY_W'(DAYS)) ? DAY_W'(DAYS) : DAY_W'(cfg_data);

    assign cnt_ctl.clear = cfg_accept;
    assign cnt_ctl.cmd   = cmd_reg;

    rawdc_locate #(
        .WORD_BITS (WORD_BITS),
        .WIDX_W    (WIDX_W),
        .BIT_W     (BIT_W)
    ) u_locate (
        .clk        (clk),
        .first_pos  (first_reg - POS_W'(1)),
        .last_pos   (last_reg - POS_W'(1)),
        .first_word (loc_fw),
        .first_bit  (loc_fb),
        .last_word  (loc_lw),
        .last_bit   (loc_lb)
    );

    rawdc_word_unit #(
        .WORD_BITS (WORD_BITS),
        .WIDX_W    (WIDX_W),
        .BIT_W     (BIT_W)
    ) u_word_unit (
        .old_word   (mem_rdata_reg),
        .word_idx   (wr_word_reg),
        .first_word (loc_fw),
        .first_bit  (loc_fb),
        .last_word  (loc_lw),
        .last_bit   (loc_lb),
        .cmd        (cmd_reg),
        .new_word   (new_word),
        .changed    (changed)
    );

    rawdc_count #(
        .WORD_BITS (WORD_BITS),
        .DAY_W     (DAY_W)
    ) u_count (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (cnt_ctl),
        .in_valid   (wr_v_reg),
        .in_bits    (changed),
        .busy       (cnt_busy),
        .idle_count (idle_count)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == WIDX_W'(MEM_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = in_bad ? ST_DONE : ST_LOC1;
                end
            end
            ST_LOC1:
            begin
                state_next = ST_LOC2;
            end
            ST_LOC2:
            begin
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (rd_word_reg == loc_lw)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!wr_v_reg && !cnt_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
        if (cfg_accept)
        begin
            state_next = ST_CLEAR;
        end
    end

    always_comb
    begin
        s_tready     = (state_reg == ST_IDLE);
        out_load     = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);
        wr_v_next    = (state_reg == ST_RUN);
        rd_word_next = rd_word_reg;
        clr_next     = clr_reg;
        mem_we       = wr_v_reg;
        mem_waddr    = wr_word_reg;
        mem_wdata    = new_word;
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = '0;
            clr_next  = clr_reg + WIDX_W'(1);
        end
        if (state_reg == ST_LOC2)
        begin
            rd_word_next = loc_fw;
        end
        else if ((state_reg == ST_RUN) && (rd_word_reg != loc_lw))
        begin
            rd_word_next = rd_word_reg + WIDX_W'(1);
        end
        if (cfg_accept)
        begin
            clr_next = '0;
        end
        days_next      = cfg_accept ? cfg_sat : days_reg;
        out_valid_next = out_load || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            days_reg      <= DAY_W'(DAYS);
            rd_word_reg   <= '0;
            wr_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            days_reg      <= days_next;
            rd_word_reg   <= rd_word_next;
            wr_v_reg      <= wr_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            cmd_reg   <= s_tuser[0];
            first_reg <= in_first;
            last_reg  <= in_last;
            bad_reg   <= in_bad;
        end
        wr_word_reg <= rd_word_reg;
        if (out_load)
        begin
            out_days_reg <= POS_W'(days_reg - idle_count);
            out_rej_reg  <= bad_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[rd_word_reg];
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {{(M_TDATA_W - POS_W){1'b0}}, out_days_reg};
    assign m_tuser[0] = out_rej_reg;

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        idle_count <= days_reg)
        else $error("Non-working day count exceeds the number of days.");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> ((rd_word_reg >= loc_fw) && (rd_word_reg <= loc_lw)))
        else $error("Word walk left the range of the transaction.");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mem_we)
        else $error("Bitmap written while the sequencer is idle.");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("Result presented without finishing a transaction.");

endmodule

`default_nettype wire
